>>> hw/rtl/e2q_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler-to-quaternion pipeline.
// Depends on nothing; used by e2q_cordic, e2q_combine and euler_to_quaternion.
package e2q_pkg;

  localparam int ANGLE_W   = 16;
  localparam int QUAT_W    = 16;
  localparam int LANES     = 3;
  localparam int STEPS     = 20;
  localparam int FRAC      = 28;
  localparam int WORK_W    = 32;
  localparam int OUT_SHIFT = FRAC - (QUAT_W - 1);

  localparam logic signed [17:0] HALF_TURN = 18'sd46080;
  localparam logic signed [17:0] QUARTER   = 18'sd11520;
  localparam logic signed [17:0] QUARTER2  = 18'sd23040;
  localparam logic signed [17:0] QUARTER3  = 18'sd34560;
  localparam logic signed [WORK_W-1:0] CORDIC_START = 32'sd163008219;

  typedef logic signed [WORK_W-1:0] work_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic [1:0] quad_t;
  typedef logic signed [WORK_W+1:0] wide_t;

  typedef struct packed {
    logic  vld;
    logic  func;
    work_t ch;
    work_t sh;
    work_t cp;
    work_t sp;
    work_t cb;
    work_t sb;
  } trig_t;

  function automatic work_t atan_at(input int idx);
    work_t v;
    case (idx)
      0:  v = 32'sd377487360;
      1:  v = 32'sd222843801;
      2:  v = 32'sd117744544;
      3:  v = 32'sd59768969;
      4:  v = 32'sd30000467;
      5:  v = 32'sd15014858;
      6:  v = 32'sd7509261;
      7:  v = 32'sd3754860;
      8:  v = 32'sd1877459;
      9:  v = 32'sd938733;
      10: v = 32'sd469367;
      11: v = 32'sd234683;
      12: v = 32'sd117342;
      13: v = 32'sd58671;
      14: v = 32'sd29335;
      15: v = 32'sd14668;
      16: v = 32'sd7334;
      17: v = 32'sd3667;
      18: v = 32'sd1833;
      default: v = 32'sd917;
    endcase
    return v;
  endfunction

  function automatic work_t mulq(input work_t a, input work_t b);
    logic signed [2*WORK_W-1:0] p;
    logic signed [2*WORK_W-1:0] t;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    t = p >>> FRAC;
    return t[WORK_W-1:0];
  endfunction

  function automatic wide_t widen(input work_t a);
    return {{2{a[WORK_W-1]}}, a};
  endfunction

  function automatic quat_t to_out(input wide_t v, input logic neg);
    wide_t r;
    wide_t hi;
    wide_t lo;
    hi = wide_t'((34'sd1 <<< (QUAT_W - 1)) - 34'sd1);
    lo = -hi - 34'sd1;
    r = (v + (34'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (neg) begin
      r = -r;
    end
    if (r > hi) begin
      r = hi;
    end
    if (r < lo) begin
      r = lo;
    end
    return r[QUAT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/euler_to_quaternion.sv
// Top level: Euler angles (1/64 degree) to Q1.15 rotation quaternion.
// Depends on e2q_pkg, e2q_cordic and e2q_combine.
//
//   channel | strobe       | payload
//   --------+--------------+-------------------------------------
//   input   | start, busy  | func, heading, pitch, bank
//   result  | done         | quat_w, quat_x, quat_y, quat_z
//
// One item per cycle; each result passes in turn through the reduction, CORDIC,
// quadrant fix-up, and products and rounding stages.
// busy is always low: the pipeline never stalls and the receiver cannot stall.
// Synchronous reset clears the valid bits; items in flight are dropped.
module euler_to_quaternion (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             func,
  input  e2q_pkg::angle_t  heading,
  input  e2q_pkg::angle_t  pitch,
  input  e2q_pkg::angle_t  bank,
  output logic             done,
  output e2q_pkg::quat_t   quat_w,
  output e2q_pkg::quat_t   quat_x,
  output e2q_pkg::quat_t   quat_y,
  output e2q_pkg::quat_t   quat_z
);

  e2q_pkg::trig_t trig;

  assign busy = 1'b0;

  e2q_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .func    (func),
    .heading (heading),
    .pitch   (pitch),
    .bank    (bank),
    .trig    (trig)
  );

  e2q_combine u_combine (
    .clk    (clk),
    .rst    (rst),
    .trig   (trig),
    .done   (done),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z)
  );

endmodule

>>> hw/rtl/e2q_cordic.sv
// Half-angle reduction, pipelined rotation CORDIC and quadrant fix-up for three angles.
// Depends on e2q_pkg.
module e2q_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  e2q_pkg::angle_t   heading,
  input  e2q_pkg::angle_t   pitch,
  input  e2q_pkg::angle_t   bank,
  output e2q_pkg::trig_t    trig
);

  logic                  vld   [e2q_pkg::STEPS+1];
  logic                  fn    [e2q_pkg::STEPS+1];
  e2q_pkg::quad_t        quad  [e2q_pkg::STEPS+1][e2q_pkg::LANES];
  e2q_pkg::work_t        xr    [e2q_pkg::STEPS+1][e2q_pkg::LANES];
  e2q_pkg::work_t        yr    [e2q_pkg::STEPS+1][e2q_pkg::LANES];
  e2q_pkg::work_t        zr    [e2q_pkg::STEPS+1][e2q_pkg::LANES];
  e2q_pkg::quad_t        q_in  [e2q_pkg::LANES];
  logic signed [17:0]    r_in  [e2q_pkg::LANES];
  e2q_pkg::angle_t       ang   [e2q_pkg::LANES];
  e2q_pkg::work_t        c_out [e2q_pkg::LANES];
  e2q_pkg::work_t        s_out [e2q_pkg::LANES];

  assign ang[0] = heading;
  assign ang[1] = pitch;
  assign ang[2] = bank;

  always_comb begin
    for (int l = 0; l < e2q_pkg::LANES; l++) begin
      logic signed [17:0] a;
      logic signed [17:0] m;
      a = {{2{ang[l][e2q_pkg::ANGLE_W-1]}}, ang[l]};
      m = (a < 0) ? a + e2q_pkg::HALF_TURN : a;
      if (m >= e2q_pkg::QUARTER3) begin
        q_in[l] = 2'd3;
        r_in[l] = m - e2q_pkg::QUARTER3;
      end else if (m >= e2q_pkg::QUARTER2) begin
        q_in[l] = 2'd2;
        r_in[l] = m - e2q_pkg::QUARTER2;
      end else if (m >= e2q_pkg::QUARTER) begin
        q_in[l] = 2'd1;
        r_in[l] = m - e2q_pkg::QUARTER;
      end else begin
        q_in[l] = 2'd0;
        r_in[l] = m;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld[0] <= rst ? 1'b0 : start;
    fn[0]  <= func;
    for (int l = 0; l < e2q_pkg::LANES; l++) begin
      quad[0][l] <= q_in[l];
      xr[0][l]   <= e2q_pkg::CORDIC_START;
      yr[0][l]   <= '0;
      zr[0][l]   <= {r_in[l][15:0], 16'b0};
    end
    for (int s = 0; s < e2q_pkg::STEPS; s++) begin
      vld[s+1] <= rst ? 1'b0 : vld[s];
      fn[s+1]  <= fn[s];
      for (int l = 0; l < e2q_pkg::LANES; l++) begin
        quad[s+1][l] <= quad[s][l];
        if (!zr[s][l][e2q_pkg::WORK_W-1]) begin
          xr[s+1][l] <= xr[s][l] - (yr[s][l] >>> s);
          yr[s+1][l] <= yr[s][l] + (xr[s][l] >>> s);
          zr[s+1][l] <= zr[s][l] - e2q_pkg::atan_at(s);
        end else begin
          xr[s+1][l] <= xr[s][l] + (yr[s][l] >>> s);
          yr[s+1][l] <= yr[s][l] - (xr[s][l] >>> s);
          zr[s+1][l] <= zr[s][l] + e2q_pkg::atan_at(s);
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < e2q_pkg::LANES; l++) begin
      case (quad[e2q_pkg::STEPS][l])
        2'd0: begin
          c_out[l] = xr[e2q_pkg::STEPS][l];
          s_out[l] = yr[e2q_pkg::STEPS][l];
        end
        2'd1: begin
          c_out[l] = -yr[e2q_pkg::STEPS][l];
          s_out[l] = xr[e2q_pkg::STEPS][l];
        end
        2'd2: begin
          c_out[l] = -xr[e2q_pkg::STEPS][l];
          s_out[l] = -yr[e2q_pkg::STEPS][l];
        end
        default: begin
          c_out[l] = yr[e2q_pkg::STEPS][l];
          s_out[l] = -xr[e2q_pkg::STEPS][l];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    trig.vld  <= rst ? 1'b0 : vld[e2q_pkg::STEPS];
    trig.func <= fn[e2q_pkg::STEPS];
    trig.ch   <= c_out[0];
    trig.sh   <= s_out[0];
    trig.cp   <= c_out[1];
    trig.sp   <= s_out[1];
    trig.cb   <= c_out[2];
    trig.sb   <= s_out[2];
  end

endmodule

>>> hw/rtl/e2q_combine.sv
// Product pipeline that combines the half-angle sines and cosines into the quaternion.
// Depends on e2q_pkg.
module e2q_combine (
  input  logic             clk,
  input  logic             rst,
  input  e2q_pkg::trig_t   trig,
  output logic             done,
  output e2q_pkg::quat_t   quat_w,
  output e2q_pkg::quat_t   quat_x,
  output e2q_pkg::quat_t   quat_y,
  output e2q_pkg::quat_t   quat_z
);

  logic           a_vld;
  logic           a_func;
  e2q_pkg::work_t a_chcp;
  e2q_pkg::work_t a_shsp;
  e2q_pkg::work_t a_chsp;
  e2q_pkg::work_t a_shcp;
  e2q_pkg::work_t a_cb;
  e2q_pkg::work_t a_sb;

  logic           b_vld;
  logic           b_func;
  e2q_pkg::work_t b_w0;
  e2q_pkg::work_t b_w1;
  e2q_pkg::work_t b_x0;
  e2q_pkg::work_t b_x1;
  e2q_pkg::work_t b_y0;
  e2q_pkg::work_t b_y1;
  e2q_pkg::work_t b_z0;
  e2q_pkg::work_t b_z1;

  always_ff @(posedge clk) begin
    a_vld  <= rst ? 1'b0 : trig.vld;
    a_func <= trig.func;
    a_chcp <= e2q_pkg::mulq(trig.ch, trig.cp);
    a_shsp <= e2q_pkg::mulq(trig.sh, trig.sp);
    a_chsp <= e2q_pkg::mulq(trig.ch, trig.sp);
    a_shcp <= e2q_pkg::mulq(trig.sh, trig.cp);
    a_cb   <= trig.cb;
    a_sb   <= trig.sb;
  end

  always_ff @(posedge clk) begin
    b_vld  <= rst ? 1'b0 : a_vld;
    b_func <= a_func;
    b_w0   <= e2q_pkg::mulq(a_chcp, a_cb);
    b_w1   <= e2q_pkg::mulq(a_shsp, a_sb);
    b_x0   <= e2q_pkg::mulq(a_chsp, a_cb);
    b_x1   <= e2q_pkg::mulq(a_shcp, a_sb);
    b_y0   <= e2q_pkg::mulq(a_shcp, a_cb);
    b_y1   <= e2q_pkg::mulq(a_chsp, a_sb);
    b_z0   <= e2q_pkg::mulq(a_chcp, a_sb);
    b_z1   <= e2q_pkg::mulq(a_shsp, a_cb);
  end

  always_ff @(posedge clk) begin
    done   <= rst ? 1'b0 : b_vld;
    quat_w <= e2q_pkg::to_out(e2q_pkg::widen(b_w0) + e2q_pkg::widen(b_w1), 1'b0);
    quat_x <= e2q_pkg::to_out(e2q_pkg::widen(b_x0) + e2q_pkg::widen(b_x1), b_func);
    quat_y <= e2q_pkg::to_out(e2q_pkg::widen(b_y0) - e2q_pkg::widen(b_y1), b_func);
    quat_z <= e2q_pkg::to_out(e2q_pkg::widen(b_z0) - e2q_pkg::widen(b_z1), b_func);
  end

endmodule
